### design/qap9_pkg.sv
package qap9_pkg;

  localparam int unsigned NumTaps    = 9;
  localparam int unsigned TapWidth   = 8;
  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned DataWidth  = 32;

  typedef logic [TapWidth-1:0] byte_t;

  // Register map, one 32-bit word per register.
  typedef enum logic [2:0] {
    RegKernelSize      = 3'd0,
    RegPadValue        = 3'd1,
    RegSumBias         = 3'd2,
    RegScaleMultiplier = 3'd3,
    RegScaleShift      = 3'd4,
    RegOutputZeroPoint = 3'd5,
    RegClampMin        = 3'd6,
    RegClampMax        = 3'd7
  } reg_index_t;

  localparam logic [3:0]  KernelSizeReset      = 4'd9;
  localparam logic [7:0]  PadValueReset        = 8'd0;
  localparam logic [24:0] SumBiasReset         = 25'd0;
  localparam logic [30:0] ScaleMultiplierReset = 31'h4000_0000;
  localparam logic [5:0]  ScaleShiftReset      = 6'd31;
  localparam logic [7:0]  OutputZeroPointReset = 8'd0;
  localparam logic [7:0]  ClampMinReset        = 8'd0;
  localparam logic [7:0]  ClampMaxReset        = 8'd255;

endpackage

### design/quantized_avg_pool_9tap_core.sv
// Nine-tap quantised average pooling core with requantisation to a byte.
// Throughput: one request per cycle unless the output stalls; six pipeline stages, with
// the output register last. The pipeline valid bits clear on a synchronous active-high
// reset, and the configuration registers return to their reset values.
module quantized_avg_pool_9tap_core (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qap9_pkg::AddrWidth-1:0] paddr,
  input  logic [qap9_pkg::DataWidth-1:0] pwdata,
  output logic [qap9_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  // Request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qap9_pkg::byte_t               tap_0,
  input  qap9_pkg::byte_t               tap_1,
  input  qap9_pkg::byte_t               tap_2,
  input  qap9_pkg::byte_t               tap_3,
  input  qap9_pkg::byte_t               tap_4,
  input  qap9_pkg::byte_t               tap_5,
  input  qap9_pkg::byte_t               tap_6,
  input  qap9_pkg::byte_t               tap_7,
  input  qap9_pkg::byte_t               tap_8,
  input  logic                          pixel_end_in,
  input  logic                          batch_end_in,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output qap9_pkg::byte_t               pooled_value,
  output logic                          pixel_end_out,
  output logic                          batch_end_out
);

  import qap9_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase of a write.
  // ---------------------------------------------------------------------------
  logic [3:0]  kernel_size;
  byte_t       pad_value;
  logic [24:0] sum_bias;
  logic [30:0] scale_multiplier;
  logic [5:0]  scale_shift;
  byte_t       output_zero_point;
  byte_t       clamp_min;
  byte_t       clamp_max;

  reg_index_t  reg_index;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign reg_index = reg_index_t'(paddr[AddrWidth-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size       <= KernelSizeReset;
      pad_value         <= PadValueReset;
      sum_bias          <= SumBiasReset;
      scale_multiplier  <= ScaleMultiplierReset;
      scale_shift       <= ScaleShiftReset;
      output_zero_point <= OutputZeroPointReset;
      clamp_min         <= ClampMinReset;
      clamp_max         <= ClampMaxReset;
    end else if (cfg_write) begin
      unique case (reg_index)
        RegKernelSize:      kernel_size       <= pwdata[3:0];
        RegPadValue:        pad_value         <= pwdata[7:0];
        RegSumBias:         sum_bias          <= pwdata[24:0];
        RegScaleMultiplier: scale_multiplier  <= pwdata[30:0];
        RegScaleShift:      scale_shift       <= pwdata[5:0];
        RegOutputZeroPoint: output_zero_point <= pwdata[7:0];
        RegClampMin:        clamp_min         <= pwdata[7:0];
        RegClampMax:        clamp_max         <= pwdata[7:0];
        default:            ;
      endcase
    end
  end

  // Read data is returned combinationally; each register is zero-extended.
  always_comb begin
    unique case (reg_index)
      RegKernelSize:      prdata = {28'd0, kernel_size};
      RegPadValue:        prdata = {24'd0, pad_value};
      RegSumBias:         prdata = {7'd0, sum_bias};
      RegScaleMultiplier: prdata = {1'b0, scale_multiplier};
      RegScaleShift:      prdata = {26'd0, scale_shift};
      RegOutputZeroPoint: prdata = {24'd0, output_zero_point};
      RegClampMin:        prdata = {24'd0, clamp_min};
      RegClampMax:        prdata = {24'd0, clamp_max};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage may load when it is empty or when the
  // stage after it is loading, so bubbles are squeezed out and a stall at the
  // output holds every occupied stage without losing or repeating a request.
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic s1_load, s2_load, s3_load, s4_load, s5_load, s6_load;

  assign s6_load  = !s6_valid || out_ready;
  assign s5_load  = !s5_valid || s6_load;
  assign s4_load  = !s4_valid || s5_load;
  assign s3_load  = !s3_valid || s4_load;
  assign s2_load  = !s2_valid || s3_load;
  assign s1_load  = !s1_valid || s2_load;
  assign in_ready = s1_load;
  assign out_valid = s6_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= in_valid;
      if (s2_load) s2_valid <= s1_valid;
      if (s3_load) s3_valid <= s2_valid;
      if (s4_load) s4_valid <= s3_valid;
      if (s5_load) s5_valid <= s4_valid;
      if (s6_load) s6_valid <= s5_valid;
    end
  end

  // The end flags travel alongside the data through every stage.
  logic [1:0] s1_flags, s2_flags, s3_flags, s4_flags, s5_flags;

  // ---------------------------------------------------------------------------
  // Stage 1: pad substitution and the nine-byte sum (at most 2295, 12 bits).
  // Tap 0 is always a real sample, so a kernel size of zero behaves as one.
  // ---------------------------------------------------------------------------
  byte_t       taps [NumTaps];
  byte_t       taps_sel [NumTaps];
  logic [11:0] tap_sum;
  logic [11:0] s1_sum;

  assign taps[0] = tap_0;
  assign taps[1] = tap_1;
  assign taps[2] = tap_2;
  assign taps[3] = tap_3;
  assign taps[4] = tap_4;
  assign taps[5] = tap_5;
  assign taps[6] = tap_6;
  assign taps[7] = tap_7;
  assign taps[8] = tap_8;

  always_comb begin
    tap_sum = '0;
    for (int i = 0; i < NumTaps; i++) begin
      if (i > 0 && 4'(i) >= kernel_size) begin
        taps_sel[i] = pad_value;
      end else begin
        taps_sel[i] = taps[i];
      end
      tap_sum = tap_sum + {4'd0, taps_sel[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_sum   <= tap_sum;
      s1_flags <= {batch_end_in, pixel_end_in};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: add the signed bias. The accumulator needs 26 signed bits.
  // ---------------------------------------------------------------------------
  logic signed [25:0] s2_acc;

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_acc   <= $signed({14'd0, s1_sum}) + $signed({sum_bias[24], sum_bias});
      s2_flags <= s1_flags;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: one 26 by 32 signed multiply. The magnitude of the product stays
  // below 2^56, so 57 signed bits hold it exactly.
  // ---------------------------------------------------------------------------
  logic signed [57:0] product_full;
  logic signed [56:0] s3_prod;

  assign product_full = s2_acc * $signed({1'b0, scale_multiplier});

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_prod  <= product_full[56:0];
      s3_flags <= s2_flags;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: split into sign and magnitude, since rounding is symmetric about
  // zero.
  // ---------------------------------------------------------------------------
  logic [56:0] prod_abs;
  logic [55:0] s4_mag;
  logic        s4_neg;

  assign prod_abs = s3_prod[56] ? 57'(-s3_prod) : 57'(s3_prod);

  always_ff @(posedge clk) begin
    if (s4_load) begin
      s4_mag   <= prod_abs[55:0];
      s4_neg   <= s3_prod[56];
      s4_flags <= s3_flags;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: barrel shift and the round-half-to-even decision. The round bit
  // is the bit just below the cut and the sticky bit ORs everything beneath
  // it; a shift of zero keeps the magnitude unrounded.
  // ---------------------------------------------------------------------------
  logic [63:0] mag_wide;
  logic [5:0]  shift_less_one;
  logic [63:0] sticky_mask;
  logic [55:0] mag_shifted;
  logic        round_bit;
  logic        sticky_bit;
  logic [55:0] s5_quot;
  logic        s5_inc;
  logic        s5_neg;

  assign mag_wide       = {8'd0, s4_mag};
  assign shift_less_one = scale_shift - 6'd1;
  assign sticky_mask    = (64'd1 << shift_less_one) - 64'd1;
  assign mag_shifted    = s4_mag >> scale_shift;
  assign round_bit      = (scale_shift != 6'd0) && mag_wide[shift_less_one];
  assign sticky_bit     = (scale_shift != 6'd0) && (|(mag_wide & sticky_mask));

  always_ff @(posedge clk) begin
    if (s5_load) begin
      s5_quot  <= mag_shifted;
      s5_inc   <= round_bit && (sticky_bit || mag_shifted[0]);
      s5_neg   <= s4_neg;
      s5_flags <= s4_flags;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6 (output register): apply the rounding increment, add the zero
  // point, saturate to a byte and clamp. Any rounded magnitude of 256 or more
  // saturates outright, so only the low byte goes through the adder.
  // ---------------------------------------------------------------------------
  logic [56:0] quot_rounded;
  logic        quot_big;
  logic [8:0]  zp_sum;
  byte_t       sat_value;
  byte_t       lo_clamped;
  byte_t       result_value;

  always_comb begin
    quot_rounded = {1'b0, s5_quot} + {56'd0, s5_inc};
    quot_big     = |quot_rounded[56:8];
    if (s5_neg) begin
      zp_sum = {1'b0, output_zero_point} - {1'b0, quot_rounded[7:0]};
      if (quot_big || zp_sum[8]) begin
        sat_value = 8'd0;
      end else begin
        sat_value = zp_sum[7:0];
      end
    end else begin
      zp_sum = {1'b0, output_zero_point} + {1'b0, quot_rounded[7:0]};
      if (quot_big || zp_sum[8]) begin
        sat_value = 8'd255;
      end else begin
        sat_value = zp_sum[7:0];
      end
    end
    // The lower clamp is applied first, so an inverted pair yields clamp_max.
    lo_clamped   = (sat_value < clamp_min) ? clamp_min : sat_value;
    result_value = (lo_clamped > clamp_max) ? clamp_max : lo_clamped;
  end

  always_ff @(posedge clk) begin
    if (s6_load) begin
      pooled_value  <= result_value;
      pixel_end_out <= s5_flags[0];
      batch_end_out <= s5_flags[1];
    end
  end

endmodule

### verif/tb_quantized_avg_pool_9tap_core.sv
module tb_quantized_avg_pool_9tap_core;
  timeunit 1ns;
  timeprecision 1ps;

  import qap9_pkg::*;

  // Settling time, ample to let the pipeline empty before any register is rewritten, and
  // before the final verdict.
  localparam int SettleCycles  = 12;
  localparam int CycleLimit    = 200_000;
  localparam int FixedPhases   = 10;
  localparam int RandomPhases  = 4;
  localparam int WindowsPerRun = 50;

  // One request: the nine window bytes of a channel plus the two end markers.
  typedef struct packed {
    byte_t [NumTaps-1:0] taps;
    logic                pixel_end;
    logic                batch_end;
  } window_t;

  // One result as it should appear on the output channel.
  typedef struct packed {
    byte_t pooled;
    logic  pixel_end;
    logic  batch_end;
  } pooled_t;

  // Local copy of the register file, kept in step with every write on the config port.
  typedef struct {
    logic [3:0]         kernel_size;
    logic [7:0]         pad_value;
    logic signed [24:0] sum_bias;
    logic [30:0]        scale_multiplier;
    logic [5:0]         scale_shift;
    logic [7:0]         zero_point;
    logic [7:0]         clamp_min;
    logic [7:0]         clamp_max;
  } pool_cfg_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  byte_t                tap_0 = '0;
  byte_t                tap_1 = '0;
  byte_t                tap_2 = '0;
  byte_t                tap_3 = '0;
  byte_t                tap_4 = '0;
  byte_t                tap_5 = '0;
  byte_t                tap_6 = '0;
  byte_t                tap_7 = '0;
  byte_t                tap_8 = '0;
  logic                 pixel_end_in = 1'b0;
  logic                 batch_end_in = 1'b0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  byte_t                pooled_value;
  logic                 pixel_end_out;
  logic                 batch_end_out;

  pool_cfg_t live_cfg = '{
    kernel_size:      KernelSizeReset,
    pad_value:        PadValueReset,
    sum_bias:         SumBiasReset,
    scale_multiplier: ScaleMultiplierReset,
    scale_shift:      ScaleShiftReset,
    zero_point:       OutputZeroPointReset,
    clamp_min:        ClampMinReset,
    clamp_max:        ClampMaxReset
  };

  // Requests waiting to be offered; the head stays on the port until it is accepted.
  window_t windows_to_send[$];
  // Results predicted for accepted requests, oldest first.
  pooled_t pooled_due[$];
  int      fault_count = 0;
  // While set, neither side inserts bubbles, so the core runs at full rate.
  bit      steady_run = 1'b0;

  quantized_avg_pool_9tap_core dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .tap_0         (tap_0),
    .tap_1         (tap_1),
    .tap_2         (tap_2),
    .tap_3         (tap_3),
    .tap_4         (tap_4),
    .tap_5         (tap_5),
    .tap_6         (tap_6),
    .tap_7         (tap_7),
    .tap_8         (tap_8),
    .pixel_end_in  (pixel_end_in),
    .batch_end_in  (batch_end_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pooled_value  (pooled_value),
    .pixel_end_out (pixel_end_out),
    .batch_end_out (batch_end_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Roughly one cycle in ten is a bubble, except during the steady stretch.
  function automatic bit take_break();
    return !steady_run && ($urandom_range(0, 99) < 10);
  endfunction

  // Expected output for one window under the current register settings.
  // The sum is formed from real taps and pad bytes, biased, multiplied and then divided
  // by a power of two with ties going to the even neighbour. The rounding works on the
  // magnitude, so negative values round symmetrically. A shift of zero leaves the
  // product untouched. Afterwards the zero point is added, the value saturates to a
  // byte, and the clamps are applied: min first, then max, so a crossed pair yields max.
  function automatic pooled_t pool_window(input window_t w);
    longint      tap_sum;
    longint      acc;
    longint      product;
    longint      scaled;
    logic [63:0] mag;
    logic [63:0] quot;
    logic [63:0] rem;
    logic [63:0] half;
    int          i;
    pooled_t     r;
    tap_sum = 0;
    // Tap 0 always counts, so a kernel size of zero behaves like one.
    for (i = 0; i < NumTaps; i++) begin
      if (i > 0 && i >= live_cfg.kernel_size) begin
        tap_sum += longint'(live_cfg.pad_value);
      end else begin
        tap_sum += longint'(w.taps[i]);
      end
    end
    acc     = tap_sum + longint'(live_cfg.sum_bias);
    product = acc * longint'(live_cfg.scale_multiplier);
    if (live_cfg.scale_shift == 0) begin
      scaled = product;
    end else begin
      mag  = (product < 0) ? -product : product;
      quot = mag >> live_cfg.scale_shift;
      rem  = mag & ((64'd1 << live_cfg.scale_shift) - 64'd1);
      half = 64'd1 << (live_cfg.scale_shift - 6'd1);
      if (rem > half || (rem == half && quot[0])) begin
        quot = quot + 64'd1;
      end
      scaled = (product < 0) ? -longint'(quot) : longint'(quot);
    end
    scaled += longint'(live_cfg.zero_point);
    if (scaled < 0) begin
      scaled = 0;
    end
    if (scaled > 255) begin
      scaled = 255;
    end
    if (scaled < longint'(live_cfg.clamp_min)) begin
      scaled = longint'(live_cfg.clamp_min);
    end
    if (scaled > longint'(live_cfg.clamp_max)) begin
      scaled = longint'(live_cfg.clamp_max);
    end
    r.pooled    = byte_t'(scaled);
    r.pixel_end = w.pixel_end;
    r.batch_end = w.batch_end;
    return r;
  endfunction

  // Request driver. The head of the queue is presented and held until the core takes
  // it; only then is it popped and its result predicted, so the prediction always uses
  // the registers that were live when the core accepted it. At most one assignment to
  // in_valid happens per edge, and none while an offer is still pending.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pooled_due.push_back(pool_window(windows_to_send[0]));
        void'(windows_to_send.pop_front());
      end
      if (in_valid && !in_ready) begin
        // Hold the current request unchanged.
      end else if (windows_to_send.size() != 0 && !take_break()) begin
        in_valid     <= 1'b1;
        tap_0        <= windows_to_send[0].taps[0];
        tap_1        <= windows_to_send[0].taps[1];
        tap_2        <= windows_to_send[0].taps[2];
        tap_3        <= windows_to_send[0].taps[3];
        tap_4        <= windows_to_send[0].taps[4];
        tap_5        <= windows_to_send[0].taps[5];
        tap_6        <= windows_to_send[0].taps[6];
        tap_7        <= windows_to_send[0].taps[7];
        tap_8        <= windows_to_send[0].taps[8];
        pixel_end_in <= windows_to_send[0].pixel_end;
        batch_end_in <= windows_to_send[0].batch_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor. Every accepted result is matched against the oldest prediction,
  // field by field; an unexpected result is a failure of its own.
  always @(posedge clk) begin
    pooled_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pooled_due.size() == 0) begin
          $error("pooled_value: result %0d arrived with no request outstanding",
                 pooled_value);
          fault_count++;
        end else begin
          want = pooled_due.pop_front();
          if (pooled_value !== want.pooled) begin
            $error("pooled_value: expected %0d, got %0d", want.pooled, pooled_value);
            fault_count++;
          end
          if (pixel_end_out !== want.pixel_end) begin
            $error("pixel_end_out: expected %0d, got %0d", want.pixel_end, pixel_end_out);
            fault_count++;
          end
          if (batch_end_out !== want.batch_end) begin
            $error("batch_end_out: expected %0d, got %0d", want.batch_end, batch_end_out);
            fault_count++;
          end
        end
      end
      out_ready <= !take_break();
    end
  end

  // A single register write: setup cycle, then access cycle, completing on the edge
  // where pready is seen high. The local copy is updated once the write has landed.
  task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegKernelSize:      live_cfg.kernel_size      = value[3:0];
      RegPadValue:        live_cfg.pad_value        = value[7:0];
      RegSumBias:         live_cfg.sum_bias         = value[24:0];
      RegScaleMultiplier: live_cfg.scale_multiplier = value[30:0];
      RegScaleShift:      live_cfg.scale_shift      = value[5:0];
      RegOutputZeroPoint: live_cfg.zero_point       = value[7:0];
      RegClampMin:        live_cfg.clamp_min        = value[7:0];
      RegClampMax:        live_cfg.clamp_max        = value[7:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input pool_cfg_t c);
    apb_write(RegKernelSize,      32'(c.kernel_size));
    apb_write(RegPadValue,        32'(c.pad_value));
    // The bias goes out sign-extended to the full data width.
    apb_write(RegSumBias,         32'(c.sum_bias));
    apb_write(RegScaleMultiplier, 32'(c.scale_multiplier));
    apb_write(RegScaleShift,      32'(c.scale_shift));
    apb_write(RegOutputZeroPoint, 32'(c.zero_point));
    apb_write(RegClampMin,        32'(c.clamp_min));
    apb_write(RegClampMax,        32'(c.clamp_max));
  endtask

  function automatic pool_cfg_t make_cfg(input logic [3:0] k, input logic [7:0] pad,
                                         input logic signed [24:0] bias,
                                         input logic [30:0] mult, input logic [5:0] shift,
                                         input logic [7:0] zp, input logic [7:0] lo,
                                         input logic [7:0] hi);
    pool_cfg_t c;
    c.kernel_size      = k;
    c.pad_value        = pad;
    c.sum_bias         = bias;
    c.scale_multiplier = mult;
    c.scale_shift      = shift;
    c.zero_point       = zp;
    c.clamp_min        = lo;
    c.clamp_max        = hi;
    return c;
  endfunction

  // Hand-picked settings, each aimed at one corner of the datapath.
  function automatic pool_cfg_t phase_setting(input int p);
    case (p)
      // A plain 3x3 average: scale of one ninth.
      0: return make_cfg(4'd9, 8'd0, 25'sd0, 31'd238609294, 6'd31, 8'd0, 8'd0, 8'd255);
      // Kernel size zero, top pad byte, largest bias and multiplier: pinned high.
      1: return make_cfg(4'd0, 8'd255, 25'h0FF_FFFF, 31'h7FFF_FFFF, 6'd47, 8'd255,
                         8'd0, 8'd255);
      // Kernel size beyond nine, most negative bias: the result hovers around zero.
      2: return make_cfg(4'd15, 8'd0, 25'h100_0000, 31'h7FFF_FFFF, 6'd47, 8'd255,
                         8'd0, 8'd255);
      // No shift at all: the biased sum goes straight through to saturation.
      3: return make_cfg(4'd5, 8'd17, -25'sd1100, 31'd1, 6'd0, 8'd0, 8'd0, 8'd255);
      // Halving with a negative bias: every odd sum is a tie, on both sides of zero.
      4: return make_cfg(4'd9, 8'd0, -25'sd1150, 31'd1, 6'd1, 8'd128, 8'd0, 8'd255);
      // Shift of 63, outside the usual range: everything rounds to nothing.
      5: return make_cfg(4'd3, 8'd99, 25'h0FF_FFFF, 31'h7FFF_FFFF, 6'd63, 8'd77,
                         8'd0, 8'd255);
      // Zero multiplier with both clamps active.
      6: return make_cfg(4'd7, 8'd1, 25'sd0, 31'd0, 6'd20, 8'd200, 8'd10, 8'd100);
      // Clamp minimum above clamp maximum: the maximum wins.
      7: return make_cfg(4'd1, 8'd255, 25'sd40, 31'd238609294, 6'd31, 8'd0, 8'd200,
                         8'd50);
      // Shortest shift in the normal range, clamps biting at both ends.
      8: return make_cfg(4'd9, 8'd0, 25'sd0, 31'd7282, 6'd16, 8'd0, 8'd30, 8'd220);
      // Kernel of ten, divide by eight: ties whenever the biased sum ends in binary 100.
      default: return make_cfg(4'd10, 8'd0, -25'sd1148, 31'd1, 6'd3, 8'd128, 8'd0,
                               8'd255);
    endcase
  endfunction

  // Mostly sensible scales (a power of two over a small divisor), with the odd fully
  // random multiplier, shift or bias thrown in.
  function automatic pool_cfg_t random_setting();
    pool_cfg_t   c;
    logic [63:0] target;
    c.kernel_size = 4'($urandom_range(0, 15));
    c.pad_value   = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      c.scale_shift = 6'($urandom_range(0, 63));
    end else begin
      c.scale_shift = 6'($urandom_range(16, 47));
    end
    target = (64'd1 << c.scale_shift) / $urandom_range(1, 12);
    if ($urandom_range(0, 3) == 0) begin
      c.scale_multiplier = 31'($urandom());
    end else if (target > 64'h7FFF_FFFF) begin
      c.scale_multiplier = 31'h7FFF_FFFF;
    end else begin
      c.scale_multiplier = target[30:0];
    end
    if ($urandom_range(0, 3) == 0) begin
      c.sum_bias = 25'($urandom());
    end else begin
      c.sum_bias = 25'(int'($urandom_range(0, 1200)) - 600);
    end
    c.zero_point = 8'($urandom_range(0, 160));
    c.clamp_min  = 8'($urandom_range(0, 60));
    c.clamp_max  = 8'($urandom_range(180, 255));
    return c;
  endfunction

  function automatic window_t uniform_window(input byte_t fill, input logic pe,
                                             input logic be);
    window_t w;
    int      i;
    for (i = 0; i < NumTaps; i++) begin
      w.taps[i] = fill;
    end
    w.pixel_end = pe;
    w.batch_end = be;
    return w;
  endfunction

  // Random windows; one in eight uses only 0 and 255 so that the extremes come often.
  function automatic window_t random_window();
    window_t w;
    bit      corner;
    int      i;
    corner = ($urandom_range(0, 7) == 0);
    for (i = 0; i < NumTaps; i++) begin
      if (corner) begin
        w.taps[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        w.taps[i] = byte_t'($urandom_range(0, 255));
      end
    end
    w.pixel_end = ($urandom_range(0, 3) == 0);
    w.batch_end = ($urandom_range(0, 15) == 0);
    return w;
  endfunction

  // Wait until every request has been taken and every result checked, then give the
  // pipeline time to empty completely.
  task automatic settle();
    while (windows_to_send.size() != 0 || pooled_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin : stimulus
    window_t w;
    int      p;
    int      i;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset settings, which halve the sum. This hits the
    // byte extremes, both tie directions and each tap position in turn.
    windows_to_send.push_back(uniform_window(8'h00, 1'b0, 1'b0));
    windows_to_send.push_back(uniform_window(8'hFF, 1'b1, 1'b1));
    windows_to_send.push_back(uniform_window(8'h55, 1'b1, 1'b0));
    windows_to_send.push_back(uniform_window(8'hAA, 1'b0, 1'b1));
    // Sums of 1, 3 and 5: halves that round to 0, 2 and 2.
    w = uniform_window(8'h00, 1'b0, 1'b0);
    w.taps[0] = 8'd1;
    windows_to_send.push_back(w);
    w.taps[0] = 8'd3;
    windows_to_send.push_back(w);
    w.taps[0] = 8'd5;
    windows_to_send.push_back(w);
    // A single full-scale tap in each position: 127.5 rounds up to 128.
    for (i = 0; i < NumTaps; i++) begin
      w = uniform_window(8'h00, i[0], i[1]);
      w.taps[i] = 8'hFF;
      windows_to_send.push_back(w);
    end
    settle();

    // Each phase reprograms every register while the core is idle, opens with an
    // all-zero and an all-ones window, then streams random windows.
    for (p = 0; p < FixedPhases + RandomPhases; p++) begin
      load_settings((p < FixedPhases) ? phase_setting(p) : random_setting());
      steady_run = (p == 0);
      windows_to_send.push_back(uniform_window(8'h00, 1'b1, 1'b0));
      windows_to_send.push_back(uniform_window(8'hFF, 1'b0, 1'b1));
      for (i = 0; i < WindowsPerRun; i++) begin
        windows_to_send.push_back(random_window());
      end
      settle();
      steady_run = 1'b0;
    end

    if (fault_count == 0) begin
      $display("tb_quantized_avg_pool_9tap_core: done, clean");
    end else begin
      $display("tb_quantized_avg_pool_9tap_core: done, errors");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CycleLimit; cycles++) begin
      @(posedge clk);
    end
    $display("tb_quantized_avg_pool_9tap_core: done, errors");
    $finish;
  end

endmodule

### files.f
design/qap9_pkg.sv
design/quantized_avg_pool_9tap_core.sv
verif/tb_quantized_avg_pool_9tap_core.sv
